// ===== design/tlptw_pkg.sv =====
// Package for the two-level page table walker: field widths, command codes
// and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package tlptw_pkg;

  localparam int CMD_W    = 2;
  localparam int LIN_W    = 24;
  localparam int PHYS_W   = 32;
  localparam int FLAGS_W  = 12;
  localparam int OFFSET_W = 12;
  localparam int PAGE_W   = LIN_W - OFFSET_W;
  localparam int FRAME_W  = PHYS_W - OFFSET_W;
  localparam int ENTRY_W  = FRAME_W + FLAGS_W;

  localparam int DIR_ENTRIES_DEF = 64;
  localparam int TBL_ENTRIES_DEF = 64;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_TRANSLATE = 2'd0;
  localparam cmd_t CMD_MAP       = 2'd1;
  localparam cmd_t CMD_REBUILD   = 2'd2;
  localparam cmd_t CMD_UNUSED    = 2'd3;

endpackage

// ===== design/tlptw_in_if.sv =====
// Request channel of the page table walker: valid, ready and one request beat.
// Depends on tlptw_pkg.
`timescale 1ns / 1ps

interface tlptw_in_if import tlptw_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [LIN_W-1:0]   linear_addr;
  logic [PHYS_W-1:0]  phys_addr;
  logic [FLAGS_W-1:0] entry_flags;

  modport source (output valid, cmd, linear_addr, phys_addr, entry_flags, input ready);
  modport sink   (input valid, cmd, linear_addr, phys_addr, entry_flags, output ready);
endinterface

// ===== design/tlptw_out_if.sv =====
// Result channel of the page table walker: valid, ready and one result beat.
// Depends on tlptw_pkg.
`timescale 1ns / 1ps

interface tlptw_out_if import tlptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PHYS_W-1:0] phys_result;

  modport source (output valid, phys_result, input ready);
  modport sink   (input valid, phys_result, output ready);
endinterface

// ===== design/two_level_page_table_walker.sv =====
// Top level of the two-level page table walker: command sequencer, sweep
// logic and output register. Depends on tlptw_pkg, tlptw_in_if, tlptw_out_if,
// tlptw_ram and tlptw_index.
`timescale 1ns / 1ps

// Usage
// The block takes request beats on in_ch (cmd, linear_addr, phys_addr,
// entry_flags) and returns exactly one result beat on out_ch per request.
// Translate returns the stored frame joined with the 12-bit page offset; map
// writes one entry with the frame from phys_addr and entry_flags and returns
// zero; rebuild rewrites every entry as an identity map carrying the flags in
// cfg_wdata's register and returns zero; the unused command returns zero.
// One request is worked on at a time. A translate goes through the states
// IDX1, IDX2, MEM, RDATA and DONE, a map through IDX1, IDX2, MEM and DONE,
// the unused command to DONE, a rebuild through SWEEP and DONE; the steps
// follow from the two-stage position unit, the registered read of the entry
// RAM and, for rebuild, the single RAM port that writes one entry per cycle.
// After reset the block sweeps every RAM entry to the identity map with zero
// flags, and in_ch.ready stays low while it does so.
// A finished result waits in the output register while out_ch is stalled;
// the next request is still accepted and worked on, and its result is held
// back until the previous beat has gone.
module two_level_page_table_walker import tlptw_pkg::*; #(
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF,
  parameter int TBL_ENTRIES = TBL_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  tlptw_in_if.sink           in_ch,
  tlptw_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [FLAGS_W-1:0] cfg_wdata
);

  // The directory is implicit, so the entry for a page sits at the page
  // number modulo the whole store depth.
  localparam int TOTAL = DIR_ENTRIES * TBL_ENTRIES;
  localparam int AW    = $clog2(TOTAL);
  localparam logic [AW-1:0] LAST_IDX = AW'(TOTAL - 1);

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_IDX1  = 3'd2;
  localparam logic [2:0] ST_IDX2  = 3'd3;
  localparam logic [2:0] ST_MEM   = 3'd4;
  localparam logic [2:0] ST_RDATA = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [FLAGS_W-1:0]  flags_r, flags_nxt;
  logic [FLAGS_W-1:0]  default_flags_r, default_flags_nxt;
  logic [FLAGS_W-1:0]  sweep_flags_r, sweep_flags_nxt;
  logic [AW-1:0]       sweep_idx_r, sweep_idx_nxt;
  logic                reply_r, reply_nxt;
  logic [PHYS_W-1:0]   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PHYS_W-1:0]   out_data_r, out_data_nxt;

  logic                ram_en;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [AW-1:0]       pos;

  tlptw_index #(
    .TOTAL (TOTAL)
  ) u_index (
    .clk    (clk),
    .page_i (page_r),
    .pos_o  (pos)
  );

  tlptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.phys_result = out_data_r;

  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    page_nxt          = page_r;
    offset_nxt        = offset_r;
    frame_nxt         = frame_r;
    flags_nxt         = flags_r;
    default_flags_nxt = cfg_we ? cfg_wdata : default_flags_r;
    sweep_flags_nxt   = sweep_flags_r;
    sweep_idx_nxt     = sweep_idx_r;
    reply_nxt         = reply_r;
    res_nxt           = res_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_data_nxt      = out_data_r;
    ram_en            = 1'b0;
    ram_we            = 1'b0;
    ram_addr          = pos;
    ram_wdata         = {frame_r, flags_r};

    case (state_r)
      ST_SWEEP: begin
        // One identity entry per cycle; the frame is the entry's position.
        ram_en        = 1'b1;
        ram_we        = 1'b1;
        ram_addr      = sweep_idx_r;
        ram_wdata     = {FRAME_W'(sweep_idx_r), sweep_flags_r};
        sweep_idx_nxt = sweep_idx_r + AW'(1);
        if (sweep_idx_r == LAST_IDX) begin
          sweep_idx_nxt = '0;
          res_nxt       = '0;
          state_nxt     = reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.cmd;
          page_nxt   = in_ch.linear_addr[LIN_W-1:OFFSET_W];
          offset_nxt = in_ch.linear_addr[OFFSET_W-1:0];
          frame_nxt  = in_ch.phys_addr[PHYS_W-1:OFFSET_W];
          flags_nxt  = in_ch.entry_flags;
          res_nxt    = '0;
          case (in_ch.cmd)
            CMD_TRANSLATE, CMD_MAP: begin
              state_nxt = ST_IDX1;
            end
            CMD_REBUILD: begin
              sweep_flags_nxt = default_flags_r;
              sweep_idx_nxt   = '0;
              reply_nxt       = 1'b1;
              state_nxt       = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_IDX1: begin
        state_nxt = ST_IDX2;
      end
      ST_IDX2: begin
        state_nxt = ST_MEM;
      end
      ST_MEM: begin
        ram_en = 1'b1;
        if (cmd_r == CMD_MAP) begin
          ram_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RDATA;
        end
      end
      ST_RDATA: begin
        res_nxt   = {ram_rdata[ENTRY_W-1:FLAGS_W], offset_r};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_SWEEP;
      default_flags_r <= '0;
      sweep_flags_r   <= '0;
      sweep_idx_r     <= '0;
      reply_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      default_flags_r <= default_flags_nxt;
      sweep_flags_r   <= sweep_flags_nxt;
      sweep_idx_r     <= sweep_idx_nxt;
      reply_r         <= reply_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    page_r     <= page_nxt;
    offset_r   <= offset_nxt;
    frame_r    <= frame_nxt;
    flags_r    <= flags_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/tlptw_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlptw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tlptw_index.sv =====
// Two-stage entry position unit: page number modulo the store depth, worked
// out by a reciprocal multiply and a back-multiply. Depends on tlptw_pkg.
`timescale 1ns / 1ps

module tlptw_index import tlptw_pkg::*; #(
  parameter int TOTAL = DIR_ENTRIES_DEF * TBL_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic [PAGE_W-1:0]        page_i,
  output logic [$clog2(TOTAL)-1:0] pos_o
);

  localparam int AW = $clog2(TOTAL);
  // ceil(2^32 / TOTAL) is exact as a quotient estimate for any 12-bit page.
  localparam longint unsigned RECIP_L = ((64'd1 << 32) + TOTAL - 1) / TOTAL;
  localparam logic [31:0] RECIP = RECIP_L[31:0];
  localparam logic [31:0] TOTAL_V = 32'(TOTAL);

  logic [PAGE_W-1:0]        quot_r;
  logic [PAGE_W-1:0]        page_r;
  logic [AW-1:0]            pos_r;
  logic [PAGE_W+31:0]       prod;
  logic [31:0]              back;
  logic [31:0]              diff;

  assign prod = {{PAGE_W{1'b0}}, RECIP} * {32'd0, page_i};
  assign back = 32'(quot_r) * TOTAL_V;
  assign diff = 32'(page_r) - back;

  always_ff @(posedge clk) begin
    quot_r <= prod[PAGE_W+31:32];
    page_r <= page_i;
    pos_r  <= diff[AW-1:0];
  end

  assign pos_o = pos_r;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for two_level_page_table_walker: a scoreboard class
// predicts each result beat, and plain tasks drive requests and the register.
// Depends on tlptw_pkg, tlptw_in_if, tlptw_out_if and the walker RTL.
`timescale 1ns / 1ps

module tb_top;
  import tlptw_pkg::*;

  // Table geometry; it must match the parameters handed to the instance below.
  localparam int DIR_N   = DIR_ENTRIES_DEF;
  localparam int TBL_N   = TBL_ENTRIES_DEF;
  localparam int SLOTS   = DIR_N * TBL_N;
  // Long enough for several times the slowest run this stimulus can make,
  // including the post-reset sweep and the capped number of rebuilds.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REBUILDS = 40;
  localparam int PHASE_BEATS  = 425;

  // The scoreboard mirrors the entry store and keeps the physical addresses
  // that the result channel still owes, oldest first.
  class translation_predictor;
    logic [ENTRY_W-1:0] page_entry [SLOTS];
    logic [FLAGS_W-1:0] rebuild_flags;
    logic [PHYS_W-1:0]  expected_phys [$];
    int                 failures;
    int                 results_checked;

    function new();
      rebuild_flags   = '0;
      failures        = 0;
      results_checked = 0;
      sweep_identity();
    endfunction

    // A rebuild writes frame p with the current default flags at slot p.
    function void sweep_identity();
      for (int p = 0; p < SLOTS; p++) begin
        page_entry[p] = {FRAME_W'(p), rebuild_flags};
      end
    endfunction

    function void set_rebuild_flags(logic [FLAGS_W-1:0] v);
      rebuild_flags = v;
    endfunction

    // The page number gives a table index and a directory index; a directory
    // index past the end wraps round.
    function int unsigned entry_slot(logic [LIN_W-1:0] lin);
      int unsigned page;
      int unsigned tbl_idx;
      int unsigned dir_idx;
      page    = int'(lin[LIN_W-1:OFFSET_W]);
      tbl_idx = (page % TBL_N) & 32'h3FF;
      dir_idx = (page / TBL_N) % DIR_N;
      return (dir_idx * TBL_N + tbl_idx) % SLOTS;
    endfunction

    function void note_request(cmd_t cmd, logic [LIN_W-1:0] lin,
                               logic [PHYS_W-1:0] phys, logic [FLAGS_W-1:0] flags);
      logic [ENTRY_W-1:0] e;
      logic [PHYS_W-1:0]  answer;
      answer = '0;
      case (cmd)
        CMD_TRANSLATE: begin
          e      = page_entry[entry_slot(lin)];
          answer = {e[ENTRY_W-1:FLAGS_W], lin[OFFSET_W-1:0]};
        end
        CMD_MAP: begin
          page_entry[entry_slot(lin)] = {phys[PHYS_W-1:OFFSET_W], flags};
        end
        CMD_REBUILD: begin
          sweep_identity();
        end
        default: begin
        end
      endcase
      expected_phys.push_back(answer);
    endfunction

    function void check_result(logic [PHYS_W-1:0] got);
      logic [PHYS_W-1:0] want;
      if (expected_phys.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result beat %h arrived with nothing outstanding", $realtime, got);
        return;
      end
      want = expected_phys.pop_front();
      results_checked++;
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%0t: phys_result mismatch, expected %h, got %h", $realtime, want, got);
      end
    endfunction

    function int pending();
      return expected_phys.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FLAGS_W-1:0] cfg_wdata;

  tlptw_in_if  req_ch ();
  tlptw_out_if rsp_ch ();

  two_level_page_table_walker #(
    .DIR_ENTRIES (DIR_N),
    .TBL_ENTRIES (TBL_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  translation_predictor sb = new();

  // When calm is set neither side idles, which gives one long stretch of
  // back-to-back traffic.
  bit calm;
  int unsigned cycle_count;
  int n_translate, n_map, n_rebuild, n_unused;
  logic [PAGE_W-1:0] hot_pages [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A cycle counter stops a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: every beat that goes across is checked against the oldest
  // expectation, and ready is dropped now and then to stall the block.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.phys_result);
    rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  // Drives one request beat and holds it until the block takes it. Valid is
  // left high at the accepting edge so that the next beat can follow at once.
  task automatic send_request(cmd_t cmd, logic [LIN_W-1:0] lin,
                              logic [PHYS_W-1:0] phys, logic [FLAGS_W-1:0] flags);
    while (!calm && $urandom_range(99) < 10) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= cmd;
    req_ch.linear_addr <= lin;
    req_ch.phys_addr   <= phys;
    req_ch.entry_flags <= flags;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(cmd, lin, phys, flags);
    case (cmd)
      CMD_TRANSLATE: n_translate++;
      CMD_MAP:       n_map++;
      CMD_REBUILD:   n_rebuild++;
      default:       n_unused++;
    endcase
  endtask

  // Lowers valid and waits until every owed result has come back, plus a
  // short margin, so that the block is idle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_default_flags(logic [FLAGS_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_rebuild_flags(v);
  endtask

  // Random traffic: mostly maps and translates over a small set of pages so
  // that translates hit entries that were just rewritten, with the odd unused
  // command, a rare rebuild and fully random addresses mixed in, after an opening rebuild.
  task automatic random_phase(int beats);
    int unsigned roll;
    logic [LIN_W-1:0] lin;
    send_request(CMD_REBUILD, LIN_W'($urandom), $urandom, FLAGS_W'($urandom));
    for (int i = 0; i < beats; i++) begin
      roll = $urandom_range(999);
      if ($urandom_range(99) < 60)
        lin = {hot_pages[$urandom_range(15)], OFFSET_W'($urandom)};
      else
        lin = LIN_W'($urandom);
      if (roll < 12 && n_rebuild < MAX_REBUILDS) begin
        send_request(CMD_REBUILD, lin, $urandom, FLAGS_W'($urandom));
      end else if (roll < 500) begin
        send_request(CMD_TRANSLATE, lin, $urandom, FLAGS_W'($urandom));
      end else if (roll < 880) begin
        hot_pages[$urandom_range(15)] = lin[LIN_W-1:OFFSET_W];
        send_request(CMD_MAP, lin, $urandom, FLAGS_W'($urandom));
      end else begin
        send_request(CMD_UNUSED, lin, $urandom, FLAGS_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_TRANSLATE;
    req_ch.linear_addr <= '0;
    req_ch.phys_addr   <= '0;
    req_ch.entry_flags <= '0;
    calm = 1'b0;
    for (int k = 0; k < 16; k++) hot_pages[k] = PAGE_W'($urandom);
    hot_pages[0] = '0;
    hot_pages[1] = '1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The block sweeps its store after reset with ready low; wait for it.
    do @(posedge clk); while (!req_ch.ready);
    write_default_flags(12'hFFF);

    // Directed part: the ends of the address range, a map that ignores the
    // low physical address bits, the unused command, neighbouring tables
    // either side of a directory boundary, and a rebuild that undoes maps.
    send_request(CMD_TRANSLATE, 24'h000000, 32'h0, 12'h0);
    send_request(CMD_TRANSLATE, 24'hFFFFFF, 32'hFFFFFFFF, 12'hFFF);
    send_request(CMD_MAP,       24'hFFFFFF, 32'hFFFFFFFF, 12'hFFF);
    send_request(CMD_TRANSLATE, 24'hFFF000, 32'h0, 12'h0);
    send_request(CMD_MAP,       24'h000ABC, 32'h12345FFF, 12'h000);
    send_request(CMD_TRANSLATE, 24'h000123, 32'h0, 12'h0);
    send_request(CMD_UNUSED,    24'hFFFFFF, 32'hFFFFFFFF, 12'hFFF);
    send_request(CMD_TRANSLATE, 24'hFFFABC, 32'h0, 12'h0);
    send_request(CMD_MAP,       24'h040000, 32'h00000000, 12'h5A5);
    send_request(CMD_TRANSLATE, 24'h040FFF, 32'h0, 12'h0);
    send_request(CMD_MAP,       24'h03F000, 32'hFEDCB000, 12'hA5A);
    send_request(CMD_TRANSLATE, 24'h03F001, 32'h0, 12'h0);
    send_request(CMD_TRANSLATE, 24'h040001, 32'h0, 12'h0);
    send_request(CMD_REBUILD,   24'hFFFFFF, 32'hFFFFFFFF, 12'hFFF);
    send_request(CMD_TRANSLATE, 24'hFFFFFF, 32'h0, 12'h0);
    send_request(CMD_TRANSLATE, 24'h000ABC, 32'h0, 12'h0);
    send_request(CMD_TRANSLATE, 24'h040000, 32'h0, 12'h0);
    send_request(CMD_MAP,       24'h123456, 32'h87654321, 12'h001);
    send_request(CMD_TRANSLATE, 24'h123000, 32'h0, 12'h0);
    send_request(CMD_UNUSED,    24'h000000, 32'h0, 12'h000);
    send_request(CMD_TRANSLATE, 24'h7FF800, 32'h0, 12'h0);

    // Random phases, each under its own default flags; the second runs with
    // no idling on either side.
    write_default_flags(12'h000);
    random_phase(PHASE_BEATS);
    write_default_flags(FLAGS_W'($urandom));
    calm = 1'b1;
    random_phase(PHASE_BEATS);
    calm = 1'b0;
    write_default_flags(12'hAAA);
    random_phase(PHASE_BEATS);
    write_default_flags(12'h555);
    random_phase(PHASE_BEATS);

    drain();
    repeat (20) @(posedge clk);

    $display("Requests: %0d translate, %0d map, %0d rebuild, %0d unused command.",
             n_translate, n_map, n_rebuild, n_unused);
    $display("Results checked: %0d, failures: %0d.", sb.results_checked, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
